// ===== rtl/sba_pkg.sv =====
// ----------------------------------------------------------------------------
// sba_pkg: shared types and constants for the stretch-between-anchors core
// Register indexes, scale defaults and the divider request/response structs.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned WideW  = 32;

  localparam logic [2:0] RegViewX   = 3'd0;
  localparam logic [2:0] RegViewY   = 3'd1;
  localparam logic [2:0] RegLongScl = 3'd2;
  localparam logic [2:0] RegLatScl  = 3'd3;
  localparam logic [2:0] RegFlatten = 3'd4;

  localparam logic [15:0] ScaleReset = 16'd4096;

  // Unit operations
  localparam logic [0:0] OpDiv  = 1'b0;
  localparam logic [0:0] OpSqrt = 1'b1;

  typedef struct packed {
    logic        go;
    logic [0:0]  op;
    logic [31:0] num;   // two's complement for divide, unsigned for sqrt
    logic [15:0] den;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic        zero_den;
    logic [31:0] res;
  } unit_rsp_t;

endpackage

// ===== rtl/sba_unit.sv =====
// ----------------------------------------------------------------------------
// sba_unit: shared bit-serial divide / square-root unit
// Signed 32 by unsigned 16 truncating divide, or 32-bit integer square root,
// one result bit per cycle, from one dividend bit (divide) or two radicand bits (sqrt).
// ----------------------------------------------------------------------------
module sba_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sba_pkg::unit_req_t req_i,
  output sba_pkg::unit_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic [0:0]  op_q, op_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;      // divide remainder / sqrt remainder
  logic [31:0] quo_q, quo_d;      // quotient / root
  logic [31:0] src_q, src_d;      // dividend magnitude / radicand, shifted out msb first
  logic [15:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic        zero_q, zero_d;

  logic [32:0] dtrial;
  logic [33:0] strial;
  logic [31:0] drem;
  logic [33:0] srem;
  logic [31:0] mag;

  always_comb begin
    mag    = req_i.num[31] ? (~req_i.num + 32'd1) : req_i.num;
    drem   = {rem_q[30:0], src_q[31]};
    dtrial = {1'b0, drem} - {17'd0, den_q};
    srem   = {rem_q, src_q[31:30]};
    strial = srem - {quo_q, 2'b01};

    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    src_d  = src_q;
    den_d  = den_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    zero_d = zero_q;

    if (!busy_q && req_i.go) begin
      op_d  = req_i.op;
      den_d = req_i.den;
      rem_d = '0;
      quo_d = '0;
      if (req_i.op == sba_pkg::OpDiv) begin
        src_d  = mag;
        neg_d  = req_i.num[31];
        cnt_d  = 6'd32;
        zero_d = (req_i.den == 16'd0);
      end else begin
        src_d  = req_i.num;
        neg_d  = 1'b0;
        cnt_d  = 6'd16;
        zero_d = 1'b0;
      end
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (op_q == sba_pkg::OpDiv) begin
        src_d = {src_q[30:0], 1'b0};
        if (!dtrial[32]) begin
          rem_d = dtrial[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = drem;
          quo_d = {quo_q[30:0], 1'b0};
        end
      end else begin
        src_d = {src_q[29:0], 2'b00};
        if (!strial[33]) begin
          rem_d = strial[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = srem[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    src_q  <= src_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  always_comb begin
    rsp_o.done     = done_q;
    rsp_o.zero_den = zero_q;
    if (zero_q) begin
      rsp_o.res = '0;
    end else if (neg_q) begin
      rsp_o.res = ~quo_q + 32'd1;
    end else begin
      rsp_o.res = quo_q;
    end
  end

endmodule

// ===== rtl/stretch_between_anchors_transform_core.sv =====
// ----------------------------------------------------------------------------
// stretch_between_anchors_transform_core: two-point stretch / rotate transform
// Stores a first endpoint, then on the second endpoint computes stretch and
// across terms with one shared iterative divide / square-root unit.
// ----------------------------------------------------------------------------
// Channel   | Handshake            | Word
// ----------+----------------------+-------------------------------------------
// command   | start / busy         | kind, anchor, offset, depth, object pos
// result    | done_o strobe        | stretch, across, move, mean depth, fault
// config    | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
//
// Sequence: a kind 0 word is taken, gives no result and leaves busy low. A
// kind 1 word holds busy through a prep state, a square root (issue, 16
// steps, done) and five divides (issue, 32 steps, done each), all on the one
// shared unit. The result strobe comes in the same cycle as busy drops.
// Reset clears the sequencer, the registers to their reset values and the
// stored first point to zero. Results show for one cycle on done_o; the
// receiver cannot stall, so nothing backs up.
// ----------------------------------------------------------------------------
module stretch_between_anchors_transform_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic signed [15:0] anchor_x_i,
  input  logic signed [15:0] anchor_y_i,
  input  logic signed [15:0] anchor_z_i,
  input  logic signed [15:0] offset_x_i,
  input  logic signed [15:0] offset_y_i,
  input  logic signed [15:0] offset_z_i,
  input  logic signed [15:0] effect_depth_i,
  input  logic signed [15:0] object_x_i,
  input  logic signed [15:0] object_y_i,
  input  logic signed [15:0] object_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [31:0] stretch_x_o,
  output logic signed [31:0] stretch_y_o,
  output logic signed [31:0] stretch_depth_o,
  output logic signed [31:0] across_x_o,
  output logic signed [31:0] across_y_o,
  output logic signed [16:0] move_x_o,
  output logic signed [16:0] move_y_o,
  output logic signed [16:0] move_z_o,
  output logic signed [15:0] mean_depth_o,
  output logic               divide_fault_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPrep  = 4'd1;
  localparam logic [3:0] StSq    = 4'd2;
  localparam logic [3:0] StSqrt  = 4'd3;
  localparam logic [3:0] StDiv0  = 4'd4;
  localparam logic [3:0] StDiv1  = 4'd5;
  localparam logic [3:0] StDiv2  = 4'd6;
  localparam logic [3:0] StDiv3  = 4'd7;
  localparam logic [3:0] StDiv4  = 4'd8;
  localparam logic [3:0] StWait  = 4'd9;

  // Configuration registers
  logic [15:0] vx_q, vy_q, lscl_q, ascl_q;
  logic        flat_q;

  // Stored first point
  logic signed [15:0] fx_q, fy_q, fz_q, fb_q;

  // Second item, latched
  logic signed [15:0] px_q, py_q, pz_q, pb_q, ox_q, oy_q, oz_q;

  // Working values
  logic [3:0]         st_q, st_d, ret_q, ret_d;
  logic signed [16:0] dx_q, dy_q, dz_q;
  logic [31:0]        len_q, nx_q, ny_q;
  logic [31:0]        r0_q, r1_q, r2_q, r3_q, r4_q;
  logic               fault_q;
  logic               done_q;

  sba_pkg::unit_req_t req;
  sba_pkg::unit_rsp_t rsp;

  sba_unit u_unit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  logic accept;
  assign accept      = start && !busy;
  assign busy        = (st_q != StIdle);
  assign cfg_ready_o = 1'b1;

  // Point combine for the incoming word
  logic signed [15:0] in_px, in_py, in_pz;
  assign in_px = anchor_x_i + offset_x_i;
  assign in_py = anchor_y_i + offset_y_i;
  assign in_pz = anchor_z_i + offset_z_i;

  // Flatten adjustments and projected depths
  logic signed [15:0] efz, epz, efb, epb, d1, d2, t1, t2;
  logic signed [15:0] sx1, sx2, sy1, sy2;
  always_comb begin
    efz = flat_q ? 16'sd0 : fz_q;
    epz = flat_q ? 16'sd0 : pz_q;
    efb = flat_q ? fb_q + 16'sd64 : fb_q;
    epb = flat_q ? pb_q + 16'sd64 : pb_q;
    // 16*(256-y) wraps into 16 bits
    t1  = efb + ((16'sd256 - fy_q) <<< 4);
    t2  = epb + ((16'sd256 - py_q) <<< 4);
    d1  = t1[15] ? 16'sd0 : t1;
    d2  = t2[15] ? 16'sd0 : t2;
    sx1 = fx_q - vx_q;
    sx2 = px_q - vx_q;
    sy1 = fy_q - efz - vy_q;
    sy2 = py_q - epz - vy_q;
  end

  // Products, combinational from the held differences
  logic signed [33:0] dx2, dy2;
  logic signed [33:0] nxp, nyp;
  logic [31:0]        sq_sum;
  assign dx2    = dx_q * dx_q;
  assign dy2    = dy_q * dy_q;
  assign nxp    = -(dy_q * $signed({1'b0, ascl_q}));
  assign nyp    = dx_q * $signed({1'b0, ascl_q});
  // Squared length wraps to 32 bits; feed it straight to the sqrt request
  assign sq_sum = dx2[31:0] + dy2[31:0];

  always_comb begin
    st_d    = st_q;
    ret_d   = ret_q;
    req.go  = 1'b0;
    req.op  = sba_pkg::OpDiv;
    req.num = '0;
    req.den = lscl_q;
    unique case (st_q)
      StIdle: begin
        if (accept && kind_i) begin
          st_d = StPrep;
        end
      end
      StPrep:  st_d = StSq;
      StSq: begin
        req.go  = 1'b1;
        req.op  = sba_pkg::OpSqrt;
        req.num = sq_sum;
        st_d    = StWait;
        ret_d   = StDiv0;
      end
      StDiv0: begin
        req.go  = 1'b1;
        req.num = {{3{dx_q[16]}}, dx_q, 12'd0};
        st_d    = StWait;
        ret_d   = StDiv1;
      end
      StDiv1: begin
        req.go  = 1'b1;
        req.num = {{3{dy_q[16]}}, dy_q, 12'd0};
        st_d    = StWait;
        ret_d   = StDiv2;
      end
      StDiv2: begin
        req.go  = 1'b1;
        req.num = {{15{dz_q[16]}}, dz_q};
        st_d    = StWait;
        ret_d   = StDiv3;
      end
      StDiv3: begin
        req.go  = 1'b1;
        req.num = nx_q;
        req.den = len_q[15:0];
        st_d    = StWait;
        ret_d   = StDiv4;
      end
      StDiv4: begin
        req.go  = 1'b1;
        req.num = ny_q;
        req.den = len_q[15:0];
        st_d    = StWait;
        ret_d   = StIdle;
      end
      StWait: begin
        if (rsp.done) begin
          st_d = ret_q;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      ret_q   <= StIdle;
      done_q  <= 1'b0;
      vx_q    <= '0;
      vy_q    <= '0;
      lscl_q  <= sba_pkg::ScaleReset;
      ascl_q  <= sba_pkg::ScaleReset;
      flat_q  <= 1'b0;
      fx_q    <= '0;
      fy_q    <= '0;
      fz_q    <= '0;
      fb_q    <= '0;
      fault_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ret_q  <= ret_d;
      done_q <= (st_q == StWait) && rsp.done && (ret_q == StIdle);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          sba_pkg::RegViewX:   vx_q   <= cfg_data_i;
          sba_pkg::RegViewY:   vy_q   <= cfg_data_i;
          sba_pkg::RegLongScl: lscl_q <= cfg_data_i;
          sba_pkg::RegLatScl:  ascl_q <= cfg_data_i;
          sba_pkg::RegFlatten: flat_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept && !kind_i) begin
        fx_q <= in_px;
        fy_q <= in_py;
        fz_q <= in_pz;
        fb_q <= effect_depth_i;
      end
      if (st_q == StPrep) begin
        fault_q <= 1'b0;
      end else if (st_q == StWait && rsp.done && rsp.zero_den) begin
        fault_q <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept && kind_i) begin
      px_q <= in_px;
      py_q <= in_py;
      pz_q <= in_pz;
      pb_q <= effect_depth_i;
      ox_q <= object_x_i;
      oy_q <= object_y_i;
      oz_q <= object_z_i;
    end
    if (st_q == StPrep) begin
      dx_q <= 17'(sx2) - 17'(sx1);
      dy_q <= 17'(sy2) - 17'(sy1);
      dz_q <= 17'(d2) - 17'(d1);
    end
    if (st_q == StSq) begin
      nx_q <= nxp[31:0];
      ny_q <= nyp[31:0];
    end
    if (st_q == StWait && rsp.done) begin
      unique case (ret_q)
        StDiv0:  len_q <= rsp.res;
        StDiv1:  r0_q  <= rsp.res;
        StDiv2:  r1_q  <= rsp.res;
        StDiv3:  r2_q  <= rsp.res;
        StDiv4:  r3_q  <= rsp.res;
        default: r4_q  <= rsp.res;
      endcase
    end
  end

  // Midpoints and mean depth, from held values
  logic signed [16:0] mx, my, mz, mb;
  logic signed [16:0] smx, smy, smz, smb;
  always_comb begin
    smx = 17'(px_q) + 17'(fx_q);
    smy = 17'(py_q) + 17'(fy_q);
    smz = 17'(epz) + 17'(efz);
    smb = 17'(epb) + 17'(efb);
    // truncate toward zero
    mx  = (smx + $signed({16'd0, smx[16]})) >>> 1;
    my  = (smy + $signed({16'd0, smy[16]})) >>> 1;
    mz  = (smz + $signed({16'd0, smz[16]})) >>> 1;
    mb  = (smb + $signed({16'd0, smb[16]})) >>> 1;
  end

  assign done_o          = done_q;
  assign stretch_x_o     = r0_q;
  assign stretch_y_o     = r1_q;
  assign stretch_depth_o = r2_q;
  assign across_x_o      = r3_q;
  assign across_y_o      = r4_q;
  assign move_x_o        = mx - 17'(ox_q);
  assign move_y_o        = my - 17'(oy_q);
  assign move_z_o        = mz - 17'(oz_q);
  assign mean_depth_o    = mb[15:0];
  assign divide_fault_o  = fault_q;

`ifndef NO_ASSERTIONS
  a_busy_on_kind1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i) |=> busy)
    else $error("kind 1 word did not start work");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the stretch-between-anchors core
// Pushes endpoint command words through start/busy, predicts each result word
// from a behavioral model of the transform and compares it on the done strobe.
// Register settings change between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CmdLatency = 400;   // generous bound on one kind 1 word

  typedef struct packed {
    logic               kind;
    logic signed [15:0] ax, ay, az, ox, oy, oz, depth, objx, objy, objz;
  } cmd_word_t;

  typedef struct packed {
    logic signed [31:0] sx, sy, sd, acx, acy;
    logic signed [16:0] mx, my, mz;
    logic signed [15:0] mdepth;
    logic               fault;
  } xform_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_word_t cmd_drv = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic done_o;
  wire xform_word_t got;

  stretch_between_anchors_transform_core dut (
    .clk_i, .rst_ni, .start, .busy,
    .kind_i(cmd_drv.kind),
    .anchor_x_i(cmd_drv.ax), .anchor_y_i(cmd_drv.ay), .anchor_z_i(cmd_drv.az),
    .offset_x_i(cmd_drv.ox), .offset_y_i(cmd_drv.oy), .offset_z_i(cmd_drv.oz),
    .effect_depth_i(cmd_drv.depth),
    .object_x_i(cmd_drv.objx), .object_y_i(cmd_drv.objy), .object_z_i(cmd_drv.objz),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o,
    .stretch_x_o(got.sx), .stretch_y_o(got.sy), .stretch_depth_o(got.sd),
    .across_x_o(got.acx), .across_y_o(got.acy),
    .move_x_o(got.mx), .move_y_o(got.my), .move_z_o(got.mz),
    .mean_depth_o(got.mdepth), .divide_fault_o(got.fault)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the registers and the stored first endpoint
  logic signed [15:0] view_x, view_y;
  logic [15:0] long_scl, lat_scl;
  logic flatten;
  logic signed [15:0] first_x, first_y, first_z, first_base;

  cmd_word_t   cmd_q[$];
  xform_word_t xform_q[$];
  int errors = 0;
  int n_results = 0, n_faults = 0, n_cmds = 0;
  bit no_gaps = 1'b0;

  // Driver-side config request, served by the clocked driver
  logic cfg_req = 1'b0;
  logic [2:0] cfg_req_idx;
  logic [15:0] cfg_req_data;

  function automatic logic signed [15:0] proj_depth(logic signed [15:0] base,
                                                    logic signed [15:0] y);
    logic signed [15:0] p;
    p = base + 16'(16 * (256 - 32'(y)));
    return (p < 0) ? 16'sd0 : p;
  endfunction

  function automatic logic [31:0] int_sqrt(logic [31:0] v);
    logic [31:0] r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Advance the endpoint model by one command word; return 1 if it yields a result
  function automatic bit transform_cmd(cmd_word_t c, output xform_word_t e);
    logic signed [15:0] px, py, pz, base, fx, fy, fz, fb, d1, d2;
    longint dx, dy, dz, nx, ny;
    logic [31:0] len;
    e = '0;
    px = c.ax + c.ox;
    py = c.ay + c.oy;
    pz = c.az + c.oz;
    base = c.depth;
    if (!c.kind) begin
      first_x = px; first_y = py; first_z = pz; first_base = base;
      return 1'b0;
    end
    fx = first_x; fy = first_y; fz = first_z; fb = first_base;
    if (flatten) begin
      fz = 0; pz = 0;
      fb = fb + 16'sd64;
      base = base + 16'sd64;
    end
    d1 = proj_depth(fb, fy);
    d2 = proj_depth(base, py);
    dx = longint'($signed(16'(px - view_x))) - longint'($signed(16'(fx - view_x)));
    dy = longint'($signed(16'(py - pz - view_y))) - longint'($signed(16'(fy - fz - view_y)));
    dz = longint'(d2) - longint'(d1);
    len = int_sqrt(32'(dx * dx + dy * dy));
    nx = longint'($signed(32'(-dy * longint'(lat_scl))));
    ny = longint'($signed(32'(dx * longint'(lat_scl))));
    if (long_scl == 0) begin
      e.fault = 1'b1;
    end else begin
      e.sx = 32'((dx * 4096) / longint'(long_scl));
      e.sy = 32'((dy * 4096) / longint'(long_scl));
      e.sd = 32'(dz / longint'(long_scl));
    end
    if (len == 0) begin
      e.fault = 1'b1;
    end else begin
      e.acx = 32'(nx / longint'(len));
      e.acy = 32'(ny / longint'(len));
    end
    e.mx = 17'((longint'(px) + fx) / 2 - c.objx);
    e.my = 17'((longint'(py) + fy) / 2 - c.objy);
    e.mz = 17'((longint'(pz) + fz) / 2 - c.objz);
    e.mdepth = 16'((longint'(base) + fb) / 2);
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint g, longint w);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, g, w, $realtime);
  endtask

  // Driver: hold start with the word until busy is low at an edge; gap in bursts
  int gap = 0;
  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) begin
      cfg_valid_i <= 1'b0;
    end else if (cfg_req && !cfg_valid_i) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_req_idx;
      cfg_data_i  <= cfg_req_data;
    end
    if (start && !busy) begin
      xform_word_t e;
      n_cmds++;
      if (transform_cmd(cmd_drv, e)) xform_q.push_back(e);
    end
    if (start && busy) begin
      // hold the word
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (cmd_q.size() > 0 && rst_ni) begin
      if (!no_gaps && $urandom_range(0, 5) == 0) begin
        gap <= $urandom_range(1, 9);
        start <= 1'b0;
      end else begin
        cmd_drv <= cmd_q.pop_front();
        start <= 1'b1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: every done strobe must match the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (xform_q.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        xform_word_t w;
        w = xform_q.pop_front();
        n_results++;
        if (w.fault) n_faults++;
        if (got.sx !== w.sx) report_mismatch("stretch_x", got.sx, w.sx);
        if (got.sy !== w.sy) report_mismatch("stretch_y", got.sy, w.sy);
        if (got.sd !== w.sd) report_mismatch("stretch_depth", got.sd, w.sd);
        if (got.acx !== w.acx) report_mismatch("across_x", got.acx, w.acx);
        if (got.acy !== w.acy) report_mismatch("across_y", got.acy, w.acy);
        if (got.mx !== w.mx) report_mismatch("move_x", got.mx, w.mx);
        if (got.my !== w.my) report_mismatch("move_y", got.my, w.my);
        if (got.mz !== w.mz) report_mismatch("move_z", got.mz, w.mz);
        if (got.mdepth !== w.mdepth) report_mismatch("mean_depth", got.mdepth, w.mdepth);
        if (got.fault !== w.fault) report_mismatch("divide_fault", got.fault, w.fault);
      end
    end
  end

  // Wait until every queued word is taken and every result has shown, then settle
  task automatic drain();
    while (cmd_q.size() > 0 || start || xform_q.size() > 0) @(posedge clk_i);
    repeat (CmdLatency) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_req_idx = idx;
    cfg_req_data = val;
    cfg_req = 1'b1;
    @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o)) @(posedge clk_i);
    cfg_req = 1'b0;
    case (idx)
      sba_pkg::RegViewX:   view_x = val;
      sba_pkg::RegViewY:   view_y = val;
      sba_pkg::RegLongScl: long_scl = val;
      sba_pkg::RegLatScl:  lat_scl = val;
      sba_pkg::RegFlatten: flatten = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_word_t rnd_cmd(logic kind);
    cmd_word_t c;
    c.kind = kind;
    c.ax = rnd16(); c.ay = rnd16(); c.az = rnd16();
    c.ox = rnd16(); c.oy = rnd16(); c.oz = rnd16();
    c.depth = rnd16();
    c.objx = rnd16(); c.objy = rnd16(); c.objz = rnd16();
    return c;
  endfunction

  // By phase mod 4: the reset value, all ones, zero, then one or a random value
  function automatic logic [15:0] scale_pick(int phase);
    case (phase % 4)
      0: return sba_pkg::ScaleReset;
      1: return 16'hffff;
      2: return 16'd0;
      default: return (phase % 3 == 0) ? 16'd1 : 16'($urandom);
    endcase
  endfunction

  initial begin
    cmd_word_t c;
    view_x = 0; view_y = 0; flatten = 0;
    long_scl = sba_pkg::ScaleReset; lat_scl = sba_pkg::ScaleReset;
    first_x = 0; first_y = 0; first_z = 0; first_base = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: kind 1 straight after reset uses the cleared first point
    c = '0; c.kind = 1'b1; cmd_q.push_back(c);
    // Zero length: identical endpoints
    c = '0; cmd_q.push_back(c); c.kind = 1'b1; cmd_q.push_back(c);
    // Field extremes on both endpoints
    c = '0; c.ax = 16'sh7fff; c.ox = 16'sh7fff; c.ay = 16'sh8000; c.depth = 16'sh7fff;
    cmd_q.push_back(c);
    c = '0; c.kind = 1'b1; c.ax = 16'sh8000; c.oy = 16'sh7fff; c.az = 16'sh8000;
    c.depth = 16'sh8000; c.objx = 16'sh7fff; c.objy = 16'sh8000; c.objz = 16'sh7fff;
    cmd_q.push_back(c);
    // Repeated kind 1 reuses the stored point
    c.objx = 16'sh8000; cmd_q.push_back(c);
    c = '1; cmd_q.push_back(c);
    c = '1; c.kind = 1'b0; cmd_q.push_back(c);
    c = '1; c.ax = 16'sh7fff; cmd_q.push_back(c);
    for (int i = 0; i < 8; i++) cmd_q.push_back(rnd_cmd(i[0]));
    drain();

    // Phases: new register settings, then mostly paired endpoints
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(sba_pkg::RegViewX,
                (ph == 1) ? 16'h7fff : (ph == 2) ? 16'h8000 : 16'($urandom));
      write_reg(sba_pkg::RegViewY,
                (ph == 1) ? 16'h8000 : (ph == 2) ? 16'h7fff : 16'($urandom));
      write_reg(sba_pkg::RegLongScl, scale_pick(ph));
      write_reg(sba_pkg::RegLatScl, scale_pick(ph + 1));
      write_reg(sba_pkg::RegFlatten, 16'(ph % 2));
      if (ph == 11) no_gaps = 1'b1;
      for (int i = 0; i < 90; i++) begin
        if ($urandom_range(0, 9) < 8) begin
          cmd_q.push_back(rnd_cmd(1'b0));
          cmd_q.push_back(rnd_cmd(1'b1));
        end else begin
          cmd_q.push_back(rnd_cmd($urandom_range(0, 1)));
        end
      end
      drain();
    end

    $display("Ran %0d command words, %0d result words (%0d with divide fault)",
             n_cmds, n_results, n_faults);
    $display("Covered 13 register settings incl. zero/max scales and flatten on/off");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: bounds a run of about 2000 words, with a wide margin
  initial begin
    #(64'd12 * 64'd4_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
